// File: rtl/yenc_pkg.sv
// Package: beat types, character codes, status codes and register indexes for the yEnc decoder.
`timescale 1ns / 1ps
`default_nettype none
package yenc_pkg;

  // Configuration port
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 1'b1;

  localparam int LINE_W = 16;
  localparam logic [LINE_W-1:0] LINE_LEN_RESET = 16'd128;
  localparam logic [LINE_W-1:0] LINE_MAX       = 16'hFFFF;

  // Character codes
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_Y  = 8'h79;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Decode offsets
  localparam logic [7:0] OFS_PLAIN = 8'd42;
  localparam logic [7:0] OFS_ESC   = 8'd106;

  // Status codes
  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BADLINE  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_NOEND    = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
    logic       source_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
  } out_beat_t;

  // Classified beat, as queued for the back end
  typedef struct packed {
    logic [7:0] plain_val;
    logic [7:0] esc_val;
    logic       is_eq;
    logic       is_y;
    logic       is_cr;
    logic       is_lf;
    logic       restart;
    logic       last;
  } cls_t;

endpackage
`default_nettype wire

// File: rtl/yenc_classify.sv
// Front end: classifies a raw body byte and precomputes both decoded values.
`timescale 1ns / 1ps
`default_nettype none
module yenc_classify (
  input  yenc_pkg::in_beat_t beat_i,
  output yenc_pkg::cls_t     cls_o
);

  always_comb begin
    cls_o.plain_val = beat_i.in_byte - yenc_pkg::OFS_PLAIN;
    cls_o.esc_val   = beat_i.in_byte - yenc_pkg::OFS_ESC;
    cls_o.is_eq     = (beat_i.in_byte == yenc_pkg::CH_EQ);
    cls_o.is_y      = (beat_i.in_byte == yenc_pkg::CH_Y);
    cls_o.is_cr     = (beat_i.in_byte == yenc_pkg::CH_CR);
    cls_o.is_lf     = (beat_i.in_byte == yenc_pkg::CH_LF);
    cls_o.restart   = beat_i.restart;
    cls_o.last      = beat_i.source_last;
  end

endmodule
`default_nettype wire

// File: rtl/yenc_fifo.sv
// Short queue of classified beats between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module yenc_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  yenc_pkg::cls_t    din_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output yenc_pkg::cls_t    dout_o,
  output logic              empty_o
);

  yenc_pkg::cls_t mem_r [yenc_pkg::QDEPTH];

  logic [yenc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [yenc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [yenc_pkg::QPTR_W:0]   cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == (yenc_pkg::QPTR_W+1)'(yenc_pkg::QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign dout_o  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= din_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/yenc_exec.sv
// Back end: decoder state, escape and line tracking, size checks, output register.
`timescale 1ns / 1ps
`default_nettype none
module yenc_exec #(
  parameter int SIZE_BITS = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  yenc_pkg::cls_t                  cls_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  input  wire logic [yenc_pkg::LINE_W-1:0] line_len_i,
  input  wire logic [SIZE_BITS-1:0]       exp_size_i,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output yenc_pkg::out_beat_t             out_data
);

  logic [SIZE_BITS-1:0]        cnt_r, cnt_nxt;
  logic [yenc_pkg::LINE_W-1:0] line_r, line_nxt;
  logic                        ls_r, ls_nxt;
  logic                        esc_r, esc_nxt;
  logic                        esc_ls_r, esc_ls_nxt;
  logic                        fin_r, fin_nxt;
  logic [2:0]                  fst_r, fst_nxt;
  logic                        ovld_r;
  yenc_pkg::out_beat_t         odata_r, odata_nxt;

  logic       store;
  logic [7:0] store_val;

  // Take the next queued beat when the output slot is free or draining
  assign pop_o     = !empty_i && (!ovld_r || out_ready);
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

  // Per-beat decode step
  always_comb begin
    cnt_nxt    = cnt_r;
    line_nxt   = line_r;
    ls_nxt     = ls_r;
    esc_nxt    = esc_r;
    esc_ls_nxt = esc_ls_r;
    fin_nxt    = fin_r;
    fst_nxt    = fst_r;
    store      = 1'b0;
    store_val  = cls_i.plain_val;
    odata_nxt  = '0;

    if (cls_i.restart) begin
      cnt_nxt    = '0;
      line_nxt   = '0;
      ls_nxt     = 1'b1;
      esc_nxt    = 1'b0;
      esc_ls_nxt = 1'b0;
      fin_nxt    = 1'b0;
      fst_nxt    = yenc_pkg::ST_RUN;
    end

    if (!fin_nxt) begin
      if (esc_nxt) begin
        esc_nxt = 1'b0;
        if (esc_ls_nxt && cls_i.is_y) begin
          fin_nxt = 1'b1;
          fst_nxt = (cnt_nxt == exp_size_i) ? yenc_pkg::ST_OK : yenc_pkg::ST_MISMATCH;
        end else begin
          store     = 1'b1;
          store_val = cls_i.esc_val;
        end
      end else if (cls_i.is_cr) begin
        if ((line_nxt != line_len_i) && (cnt_nxt != exp_size_i)) begin
          fin_nxt = 1'b1;
          fst_nxt = yenc_pkg::ST_BADLINE;
        end
      end else if (cls_i.is_lf) begin
        ls_nxt   = 1'b1;
        line_nxt = '0;
      end else if (cls_i.is_eq) begin
        esc_nxt    = 1'b1;
        esc_ls_nxt = ls_nxt;
      end else begin
        store = 1'b1;
      end

      // Data byte: room check, then count it
      if (store) begin
        if (cnt_nxt >= exp_size_i) begin
          fin_nxt = 1'b1;
          fst_nxt = yenc_pkg::ST_OVERFLOW;
        end else begin
          cnt_nxt = cnt_nxt + SIZE_BITS'(1);
          if (line_nxt != yenc_pkg::LINE_MAX) begin
            line_nxt = line_nxt + 1'b1;
          end
          ls_nxt              = 1'b0;
          odata_nxt.out_valid = 1'b1;
          odata_nxt.out_byte  = store_val;
        end
      end

      if (!fin_nxt && cls_i.last) begin
        fin_nxt = 1'b1;
        fst_nxt = yenc_pkg::ST_NOEND;
      end
    end

    odata_nxt.status = fst_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      line_r   <= '0;
      ls_r     <= 1'b1;
      esc_r    <= 1'b0;
      esc_ls_r <= 1'b0;
      fin_r    <= 1'b0;
      fst_r    <= yenc_pkg::ST_RUN;
      ovld_r   <= 1'b0;
    end else begin
      if (pop_o) begin
        cnt_r    <= cnt_nxt;
        line_r   <= line_nxt;
        ls_r     <= ls_nxt;
        esc_r    <= esc_nxt;
        esc_ls_r <= esc_ls_nxt;
        fin_r    <= fin_nxt;
        fst_r    <= fst_nxt;
        ovld_r   <= 1'b1;
      end else if (out_ready) begin
        ovld_r   <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (pop_o) begin
      odata_r <= odata_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/yenc_body_decoder.sv
// Top level of the yEnc body decoder: config registers, front end, queue, back end.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready | in_data  (in_byte, restart, source_last)
//  out_    | output    | out_valid/out_ready | out_data (out_byte, out_valid, status)
//  cfg_    | input     | cfg_we              | cfg_idx, cfg_wdata
//
// One beat in per cycle and one beat out per cycle when the sink keeps up.
// A beat is first written into the queue, then the decode step writes it into the output register.
// The rate is set by the combinational decode step in the back end.
// The 4-entry queue absorbs stalls; in_ready drops only when it is full.
// Synchronous active-low reset clears all decoder state; config resets to 128 / 0.
`timescale 1ns / 1ps
`default_nettype none
module yenc_body_decoder #(
  parameter int SIZE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  yenc_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output yenc_pkg::out_beat_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [yenc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [yenc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [yenc_pkg::LINE_W-1:0] line_len_r;
  logic [SIZE_BITS-1:0]        exp_size_r;
  logic [31:0]                 cfg_wide;

  yenc_pkg::cls_t cls_in, cls_out;
  logic           q_full, q_empty, q_pop, q_push;

  // Config registers; size is zero-extended then cut to SIZE_BITS
  assign cfg_wide = 32'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= yenc_pkg::LINE_LEN_RESET;
      exp_size_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        yenc_pkg::REG_LINE_LEN: line_len_r <= cfg_wdata[yenc_pkg::LINE_W-1:0];
        yenc_pkg::REG_SIZE:     exp_size_r <= cfg_wide[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  yenc_classify u_classify (
    .beat_i (in_data),
    .cls_o  (cls_in)
  );

  yenc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (cls_out),
    .empty_o (q_empty)
  );

  yenc_exec #(
    .SIZE_BITS (SIZE_BITS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cls_i      (cls_out),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .line_len_i (line_len_r),
    .exp_size_i (exp_size_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/yenc_checker.sv
// Port-level checker for the yEnc body decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module yenc_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input yenc_pkg::out_beat_t       out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  // A decoded byte only comes while running or on an early source end
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_valid |->
      out_data.status == yenc_pkg::ST_RUN || out_data.status == yenc_pkg::ST_NOEND)
    else $error("decoded byte with a final status");

  // No decoded byte means a zero data field
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("nonzero byte without data flag");

  // Status never takes a code outside the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= yenc_pkg::ST_MISMATCH)
    else $error("undefined status code");

endmodule

bind yenc_body_decoder yenc_checker u_yenc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
